// ----- design/bct_pkg.sv -----
// Shared widths and codes for the box collision test pipeline.
`default_nettype none
package bct_pkg;

   localparam int COORD_BITS = 32;                 // signed coordinate width
   localparam int LEN_BITS   = COORD_BITS - 1;     // unsigned length width
   localparam int SCALE_BITS = 16;                 // Q8.8 scale
   localparam int SCALE_FRAC = 8;
   localparam int PLACE_BITS = COORD_BITS + 1;     // placed left/top, no wrap
   localparam int SIZE_BITS  = LEN_BITS + SCALE_BITS - SCALE_FRAC;  // scaled w/h
   // doubled-unit differences: 2*other - (2*left + w), plus sign and headroom
   localparam int DIFF_BITS  =
      ((PLACE_BITS + 1 > SIZE_BITS + 1) ? PLACE_BITS + 1 : SIZE_BITS + 1) + 2;
   localparam int SQ_BITS    = 2 * COORD_BITS;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_CIRCLE = 2'd1,
      OP_BOX    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

endpackage
`default_nettype wire

// ----- design/bct_dist.sv -----
// Squared corner distance against squared radius: one multiply stage, compare out.
`default_nettype none
module bct_dist (
   input  logic                              clock,
   input  logic                              en,
   input  logic [bct_pkg::COORD_BITS-1:0]    ex,
   input  logic [bct_pkg::COORD_BITS-1:0]    ey,
   input  logic [bct_pkg::COORD_BITS-1:0]    r2,
   output logic                              in_range
);

   logic [bct_pkg::SQ_BITS-1:0] sq_x_ff, sq_y_ff, sq_r_ff;
   logic [bct_pkg::SQ_BITS-1:0] sq_x_in, sq_y_in, sq_r_in;

   assign sq_x_in = bct_pkg::SQ_BITS'(ex) * bct_pkg::SQ_BITS'(ex);
   assign sq_y_in = bct_pkg::SQ_BITS'(ey) * bct_pkg::SQ_BITS'(ey);
   assign sq_r_in = bct_pkg::SQ_BITS'(r2) * bct_pkg::SQ_BITS'(r2);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_r_ff <= sq_r_in;
      end
   end

   // sum carries one extra bit
   assign in_range = ((bct_pkg::SQ_BITS + 1)'(sq_x_ff) + (bct_pkg::SQ_BITS + 1)'(sq_y_ff))
                     <= (bct_pkg::SQ_BITS + 1)'(sq_r_ff);

endmodule
`default_nettype wire

// ----- design/box_collision_test.sv -----
// Top level: pipelined axis-aligned box collision query unit.
//
// One query per request: the box is placed at owner position plus the
// configured offset, sized by the configured width/height times the Q8.8
// owner scale (truncated), then tested against a point, a circle or another
// box chosen by op; every edge is inclusive and op code three answers 0.
// A new request is taken every clock cycle unless the response side stalls;
// each result is presented on the response port after passing the five
// register stages (place, difference, bound/decide, square, compare/output).
// Back-pressure on the response side stalls only the stages that hold data,
// so bubbles are squeezed out. Configuration writes take effect on the next
// request; the user must make them only while the pipeline is empty, as the
// block itself does not enforce this.
`default_nettype none
module box_collision_test (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [bct_pkg::COORD_BITS-1:0]         csr_wdata,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_op,
   input  logic signed [bct_pkg::COORD_BITS-1:0]  req_pos_x,
   input  logic signed [bct_pkg::COORD_BITS-1:0]  req_pos_y,
   input  logic [bct_pkg::SCALE_BITS-1:0]         req_scale,
   input  logic signed [bct_pkg::COORD_BITS-1:0]  req_other_x,
   input  logic signed [bct_pkg::COORD_BITS-1:0]  req_other_y,
   input  logic [bct_pkg::LEN_BITS-1:0]           req_other_width,
   input  logic [bct_pkg::LEN_BITS-1:0]           req_other_height,
   input  logic [bct_pkg::LEN_BITS-1:0]           req_circle_radius,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit
);

   localparam int CW = bct_pkg::COORD_BITS;
   localparam int LW = bct_pkg::LEN_BITS;
   localparam int PW = bct_pkg::PLACE_BITS;
   localparam int SW = bct_pkg::SIZE_BITS;
   localparam int DW = bct_pkg::DIFF_BITS;
   localparam int MW = LW + bct_pkg::SCALE_BITS;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic signed [CW-1:0] rect_offset_x_ff, rect_offset_y_ff;
   logic [LW-1:0]        rect_width_ff, rect_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_offset_x_ff <= '0;
         rect_offset_y_ff <= '0;
         rect_width_ff    <= '0;
         rect_height_ff   <= '0;
      end else if (csr_we) begin
         case (bct_pkg::csr_index_type'(csr_index))
            bct_pkg::CSR_OFFSET_X: rect_offset_x_ff <= csr_wdata;
            bct_pkg::CSR_OFFSET_Y: rect_offset_y_ff <= csr_wdata;
            bct_pkg::CSR_WIDTH:    rect_width_ff    <= csr_wdata[LW-1:0];
            bct_pkg::CSR_HEIGHT:   rect_height_ff   <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when empty or when the stage
   // after it loads
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !rsp_valid_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff        <= req_valid;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) v4_ff        <= v3_ff;
         if (en5) rsp_valid_ff <= v4_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: place the box (left/top sums, scaled width/height)
   // ------------------------------------------------------------------
   logic signed [PW-1:0] left1_ff, top1_ff, left1_in, top1_in;
   logic [SW-1:0]        w1_ff, h1_ff;
   logic [MW-1:0]        w_prod, h_prod;
   logic [1:0]           op1_ff;
   logic signed [CW-1:0] ox1_ff, oy1_ff;
   logic [LW-1:0]        ow1_ff, oh1_ff, rad1_ff;

   assign left1_in = PW'(req_pos_x) + PW'(rect_offset_x_ff);
   assign top1_in  = PW'(req_pos_y) + PW'(rect_offset_y_ff);
   assign w_prod   = MW'(rect_width_ff) * MW'(req_scale);
   assign h_prod   = MW'(rect_height_ff) * MW'(req_scale);

   always_ff @(posedge clock) begin
      if (en1) begin
         left1_ff <= left1_in;
         top1_ff  <= top1_in;
         w1_ff    <= w_prod[MW-1:bct_pkg::SCALE_FRAC];
         h1_ff    <= h_prod[MW-1:bct_pkg::SCALE_FRAC];
         op1_ff   <= req_op;
         ox1_ff   <= req_other_x;
         oy1_ff   <= req_other_y;
         ow1_ff   <= req_other_width;
         oh1_ff   <= req_other_height;
         rad1_ff  <= req_circle_radius;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: point/box interval tests, circle center distances in
   // doubled units (box center = 2*left + w)
   // ------------------------------------------------------------------
   logic signed [DW-1:0] le, te, re, be, oxe, oye, owe, ohe, we, he;
   logic signed [DW-1:0] dx, dy;
   logic                 pt_hit, box_hit, simple_in, circle_in;
   logic [DW-1:0]        dxa2_ff, dya2_ff;
   logic [SW-1:0]        w2_ff, h2_ff;
   logic [CW-1:0]        r2_2_ff;
   logic                 simple2_ff, circle2_ff;

   assign le  = DW'(left1_ff);
   assign te  = DW'(top1_ff);
   assign we  = {{(DW-SW){1'b0}}, w1_ff};
   assign he  = {{(DW-SW){1'b0}}, h1_ff};
   assign re  = le + we;
   assign be  = te + he;
   assign oxe = DW'(ox1_ff);
   assign oye = DW'(oy1_ff);
   assign owe = {{(DW-LW){1'b0}}, ow1_ff};
   assign ohe = {{(DW-LW){1'b0}}, oh1_ff};

   assign pt_hit  = (oxe >= le) && (oxe <= re) && (oye >= te) && (oye <= be);
   assign box_hit = (le <= oxe + owe) && (oxe <= re) && (te <= oye + ohe) && (oye <= be);

   assign dx = (oxe <<< 1) - ((le <<< 1) + we);
   assign dy = (oye <<< 1) - ((te <<< 1) + he);

   always_comb begin
      case (bct_pkg::op_type'(op1_ff))
         bct_pkg::OP_POINT: simple_in = pt_hit;
         bct_pkg::OP_BOX:   simple_in = box_hit;
         default:           simple_in = 1'b0;
      endcase
   end
   assign circle_in = (op1_ff == bct_pkg::OP_CIRCLE);

   always_ff @(posedge clock) begin
      if (en2) begin
         dxa2_ff    <= dx[DW-1] ? unsigned'(-dx) : unsigned'(dx);
         dya2_ff    <= dy[DW-1] ? unsigned'(-dy) : unsigned'(dy);
         w2_ff      <= w1_ff;
         h2_ff      <= h1_ff;
         r2_2_ff    <= {rad1_ff, 1'b0};
         simple2_ff <= simple_in;
         circle2_ff <= circle_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: half-extent reject/accept; leftover corner offsets fit in
   // CW bits because they never exceed the doubled radius
   // ------------------------------------------------------------------
   logic [DW-1:0] wd, hd, rd;
   logic          rej_x, rej_y, acc_x, acc_y;
   logic          dec3_in, val3_in, dec3_ff, val3_ff;
   logic [CW-1:0] ex3_ff, ey3_ff, r2_3_ff;
   logic [DW-1:0] ex_full, ey_full;

   assign wd = DW'(w2_ff);
   assign hd = DW'(h2_ff);
   assign rd = DW'(r2_2_ff);
   assign rej_x = dxa2_ff > wd + rd;
   assign rej_y = dya2_ff > hd + rd;
   assign acc_x = dxa2_ff <= wd;
   assign acc_y = dya2_ff <= hd;
   assign ex_full = dxa2_ff - wd;
   assign ey_full = dya2_ff - hd;

   always_comb begin
      if (!circle2_ff) begin
         dec3_in = 1'b1;
         val3_in = simple2_ff;
      end else if (rej_x || rej_y) begin
         dec3_in = 1'b1;
         val3_in = 1'b0;
      end else if (acc_x || acc_y) begin
         dec3_in = 1'b1;
         val3_in = 1'b1;
      end else begin
         dec3_in = 1'b0;
         val3_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         dec3_ff <= dec3_in;
         val3_ff <= val3_in;
         ex3_ff  <= ex_full[CW-1:0];
         ey3_ff  <= ey_full[CW-1:0];
         r2_3_ff <= r2_2_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: squares (inside bct_dist); stage 5: sum, compare, output
   // ------------------------------------------------------------------
   logic dec4_ff, val4_ff, in_range, rsp_hit_ff;

   bct_dist u_dist (
      .clock    (clock),
      .en       (en4),
      .ex       (ex3_ff),
      .ey       (ey3_ff),
      .r2       (r2_3_ff),
      .in_range (in_range)
   );

   always_ff @(posedge clock) begin
      if (en4) begin
         dec4_ff <= dec3_ff;
         val4_ff <= val3_ff;
      end
      if (en5) begin
         rsp_hit_ff <= dec4_ff ? val4_ff : in_range;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

`ifndef SYNTHESIS
   // corner offsets that reach the squaring stage must fit the doubled radius
   a_corner_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !dec3_ff |-> (ex3_ff <= r2_3_ff) && (ey3_ff <= r2_3_ff))
      else $error("corner offset exceeds doubled radius");

   // an accepted request always lands in stage one
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted request lost at stage one");

   // a stalled item in the square stage is not dropped
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !en4 |=> v4_ff)
      else $error("stalled item dropped at square stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
`default_nettype wire
